// File: rtl/core/voe_pkg.sv
package voe_pkg;

  // Sizing
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned PHASE_BITS     = 24;
  localparam int unsigned SINE_ENTRIES   = 1 << SINE_ADDR_BITS;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned VEL_W          = 7;
  localparam int unsigned STEP_W         = 24;
  localparam int unsigned AMP_W          = 32;
  localparam int unsigned CFG_W          = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned PEAK_ENTRIES   = 1 << VEL_W;
  localparam int unsigned SUM_W          = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

  // Register reset values
  localparam logic [CFG_W-1:0] ATTACK_SCALE_RST  = 32'd894785;
  localparam logic [CFG_W-1:0] RELEASE_SCALE_RST = 32'd99422;
  localparam logic [CFG_W-1:0] STEAL_SCALE_RST   = 32'd17895697;

  // Table generation constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q23_MAX     = 64'd8388607;
  localparam logic [63:0] PEAK_DIV    = 64'd10241915;  // 5 * 127^3
  localparam logic [5:0][63:0] TAYLOR_DIV = {64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_ATTACK  = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_STEAL   = 3'd3,
    MODE_KILL    = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_RELEASE = 2'd1,
    CFG_STEAL   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_ATTACK  = 2'd1,
    ST_RELEASE = 2'd2,
    ST_FAST    = 2'd3
  } stage_e;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_ATK_SCL,
    CS_ATK_REL,
    CS_ATK_STL,
    CS_ATK_FAST,
    CS_TCK_SQ,
    CS_TCK_S4,
    CS_TCK_S5,
    CS_TCK_AMP,
    CS_TCK_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_SQ,   // s * s
    MUL_S2,   // s2 * s2
    MUL_S4S,  // s4 * s
    MUL_AMP,  // s5 * amplitude
    MUL_ATK,  // peak * attack scale
    MUL_REL,  // peak * release scale
    MUL_STL   // peak * steal scale
  } mul_sel_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_RISE,
    CAP_FALL,
    CAP_FAST
  } cap_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    cap_sel_e cap_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic              out_free;
  } dp_status_t;

  typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_tbl_t;
  typedef logic [PEAK_ENTRIES-1:0][AMP_W-1:0]    peak_tbl_t;

  // Taylor series of sin in Q2.30, rounded to Q23 and clamped
  function automatic logic [SAMPLE_W-1:0] sine_q23(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 6; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd64) >> 7;
    return (sum > Q23_MAX) ? Q23_MAX[SAMPLE_W-1:0] : sum[SAMPLE_W-1:0];
  endfunction

  function automatic sine_tbl_t build_sine_table();
    sine_tbl_t   t;
    logic [63:0] x;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x    = (HALF_PI_Q30 * (64'(2 * i) + 64'd1)) >> (SINE_ADDR_BITS + 1);
      t[i] = sine_q23(x);
    end
    return t;
  endfunction

  // Peak amplitude 0.4 * (v/127)^3 in Q0.32
  function automatic peak_tbl_t build_peak_table();
    peak_tbl_t   t;
    logic [63:0] v;
    logic [63:0] q;
    for (int i = 0; i < PEAK_ENTRIES; i++) begin
      v    = 64'(i);
      q    = ((64'd2 * v * v * v) << 32) / PEAK_DIV;
      t[i] = q[AMP_W-1:0];
    end
    return t;
  endfunction

  localparam sine_tbl_t SINE_TABLE = build_sine_table();
  localparam peak_tbl_t PEAK_TABLE = build_peak_table();

endpackage

// File: rtl/core/voe_datapath.sv
module voe_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [voe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [voe_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [voe_pkg::MODE_W-1:0]        in_mode_i,
  input  logic [voe_pkg::VEL_W-1:0]         in_velocity_i,
  input  logic [voe_pkg::STEP_W-1:0]        in_phase_step_i,
  input  voe_pkg::dp_cmd_t                  cmd_i,
  output voe_pkg::dp_status_t               status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [voe_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                              out_note_ended_o,
  output logic                              out_active_o
);

  localparam int unsigned PB  = voe_pkg::PHASE_BITS;
  localparam int unsigned SAB = voe_pkg::SINE_ADDR_BITS;
  localparam int unsigned AW  = voe_pkg::AMP_W;
  localparam int unsigned SW  = voe_pkg::SAMPLE_W;

  logic [voe_pkg::CFG_W-1:0] atk_scale_q, rel_scale_q, stl_scale_q;
  logic [PB-1:0]             phase_q, phase_d;
  logic [AW-1:0]             amp_q, amp_d;
  logic [AW-1:0]             peak_q, peak_d;
  logic [AW-1:0]             rise_q, fall_q, fast_q;
  voe_pkg::stage_e           stage_q, stage_d;
  logic [SW-1:0]             rom_q;
  logic                      neg_q, ended_q, active_q;
  logic                      ended_d;
  logic [63:0]               prod_q;
  logic [AW-1:0]             mul_a, mul_b;
  logic [AW-1:0]             prod_hi, prod_s;
  logic [SAB-1:0]            rom_addr;
  logic [voe_pkg::SUM_W-1:0] phase_sum;
  logic [AW:0]               amp_sum;
  logic [AW-1:0]             dec_step;
  logic [SW-1:0]             mag;
  logic                      out_valid_q;
  logic signed [SW-1:0]      out_sample_q;
  logic                      out_ended_q, out_active_q;
  logic                      is_tick;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_scale_q <= voe_pkg::ATTACK_SCALE_RST;
      rel_scale_q <= voe_pkg::RELEASE_SCALE_RST;
      stl_scale_q <= voe_pkg::STEAL_SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        voe_pkg::CFG_ATTACK:  atk_scale_q <= cfg_data_i;
        voe_pkg::CFG_RELEASE: rel_scale_q <= cfg_data_i;
        voe_pkg::CFG_STEAL:   stl_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Envelope and phase update on request acceptance
  assign rom_addr  = phase_q[PB-3 -: SAB] ^ {SAB{phase_q[PB-2]}};
  assign phase_sum = voe_pkg::SUM_W'(phase_q) + voe_pkg::SUM_W'(in_phase_step_i);
  assign amp_sum   = {1'b0, amp_q} + {1'b0, rise_q};
  assign dec_step  = (stage_q == voe_pkg::ST_RELEASE) ? fall_q : fast_q;
  assign is_tick   = cmd_i.accept && (in_mode_i == voe_pkg::MODE_TICK);

  always_comb begin
    phase_d = phase_q;
    amp_d   = amp_q;
    peak_d  = peak_q;
    stage_d = stage_q;
    ended_d = 1'b0;
    if (cmd_i.accept) begin
      unique case (in_mode_i)
        voe_pkg::MODE_TICK: begin
          if (stage_q != voe_pkg::ST_IDLE) begin
            if (stage_q == voe_pkg::ST_ATTACK) begin
              if (amp_q < peak_q) begin
                amp_d = (amp_sum > {1'b0, peak_q}) ? peak_q : amp_sum[AW-1:0];
              end
            end else if (amp_q != '0) begin
              amp_d = (dec_step >= amp_q) ? '0 : amp_q - dec_step;
            end else begin
              ended_d = 1'b1;
              stage_d = voe_pkg::ST_IDLE;
            end
            phase_d = phase_sum[PB-1:0];
          end
        end
        voe_pkg::MODE_ATTACK: begin
          phase_d = '0;
          amp_d   = '0;
          peak_d  = voe_pkg::PEAK_TABLE[in_velocity_i];
          stage_d = voe_pkg::ST_ATTACK;
        end
        voe_pkg::MODE_RELEASE: begin
          if (stage_q != voe_pkg::ST_IDLE) stage_d = voe_pkg::ST_RELEASE;
        end
        voe_pkg::MODE_STEAL: begin
          if (stage_q != voe_pkg::ST_IDLE) stage_d = voe_pkg::ST_FAST;
        end
        voe_pkg::MODE_KILL: begin
          amp_d   = '0;
          stage_d = voe_pkg::ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      amp_q   <= '0;
      peak_q  <= '0;
      stage_q <= voe_pkg::ST_IDLE;
      rise_q  <= '0;
      fall_q  <= '0;
      fast_q  <= '0;
    end else begin
      phase_q <= phase_d;
      amp_q   <= amp_d;
      peak_q  <= peak_d;
      stage_q <= stage_d;
      unique case (cmd_i.cap_sel)
        voe_pkg::CAP_RISE: rise_q <= prod_hi;
        voe_pkg::CAP_FALL: fall_q <= prod_hi;
        voe_pkg::CAP_FAST: fast_q <= prod_hi;
        default: ;
      endcase
    end
  end

  // Quarter-wave ROM, read with the pre-advance phase
  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      rom_q    <= voe_pkg::SINE_TABLE[rom_addr];
      neg_q    <= phase_q[PB-1];
      ended_q  <= ended_d;
      active_q <= (stage_d != voe_pkg::ST_IDLE);
    end
  end

  // Shared multiplier
  assign prod_hi = prod_q[63:32];
  assign prod_s  = prod_q[AW+22:23];

  always_comb begin
    unique case (cmd_i.mul_sel)
      voe_pkg::MUL_SQ:  begin mul_a = AW'(rom_q); mul_b = AW'(rom_q);  end
      voe_pkg::MUL_S2:  begin mul_a = prod_s;     mul_b = prod_s;      end
      voe_pkg::MUL_S4S: begin mul_a = prod_s;     mul_b = AW'(rom_q);  end
      voe_pkg::MUL_AMP: begin mul_a = prod_s;     mul_b = amp_q;       end
      voe_pkg::MUL_ATK: begin mul_a = peak_q;     mul_b = atk_scale_q; end
      voe_pkg::MUL_REL: begin mul_a = peak_q;     mul_b = rel_scale_q; end
      voe_pkg::MUL_STL: begin mul_a = peak_q;     mul_b = stl_scale_q; end
      default:          begin mul_a = '0;         mul_b = '0;          end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Output register
  assign mag = prod_q[SW+31:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= neg_q ? SW'(-mag) : mag;
      out_ended_q  <= ended_q;
      out_active_q <= active_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_sample_q;
  assign out_note_ended_o  = out_ended_q;
  assign out_active_o      = out_active_q;
  assign status_o.in_mode  = in_mode_i;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  a_amp_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_q <= peak_q)
    else $error("amplitude above peak");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q == voe_pkg::ST_IDLE) |-> (amp_q == '0))
    else $error("idle voice with nonzero amplitude");

endmodule

// File: rtl/core/voe_ctrl.sv
module voe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  voe_pkg::dp_status_t status_i,
  output voe_pkg::dp_cmd_t    cmd_o
);

  voe_pkg::ctrl_state_e state_q, state_d;
  logic                 accept;

  assign in_ready_o = (state_q == voe_pkg::CS_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= voe_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      voe_pkg::CS_IDLE: begin
        if (accept && (status_i.in_mode == voe_pkg::MODE_TICK)) begin
          state_d = voe_pkg::CS_TCK_SQ;
        end else if (accept && (status_i.in_mode == voe_pkg::MODE_ATTACK)) begin
          state_d = voe_pkg::CS_ATK_SCL;
        end
      end
      voe_pkg::CS_ATK_SCL:  state_d = voe_pkg::CS_ATK_REL;
      voe_pkg::CS_ATK_REL:  state_d = voe_pkg::CS_ATK_STL;
      voe_pkg::CS_ATK_STL:  state_d = voe_pkg::CS_ATK_FAST;
      voe_pkg::CS_ATK_FAST: state_d = voe_pkg::CS_IDLE;
      voe_pkg::CS_TCK_SQ:   state_d = voe_pkg::CS_TCK_S4;
      voe_pkg::CS_TCK_S4:   state_d = voe_pkg::CS_TCK_S5;
      voe_pkg::CS_TCK_S5:   state_d = voe_pkg::CS_TCK_AMP;
      voe_pkg::CS_TCK_AMP:  state_d = voe_pkg::CS_TCK_OUT;
      voe_pkg::CS_TCK_OUT: begin
        if (status_i.out_free) state_d = voe_pkg::CS_IDLE;
      end
      default: state_d = voe_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.mul_sel  = voe_pkg::MUL_SQ;
    cmd_o.cap_sel  = voe_pkg::CAP_NONE;
    unique case (state_q)
      voe_pkg::CS_ATK_SCL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_ATK;
      end
      voe_pkg::CS_ATK_REL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_REL;
        cmd_o.cap_sel = voe_pkg::CAP_RISE;
      end
      voe_pkg::CS_ATK_STL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_STL;
        cmd_o.cap_sel = voe_pkg::CAP_FALL;
      end
      voe_pkg::CS_ATK_FAST: cmd_o.cap_sel = voe_pkg::CAP_FAST;
      voe_pkg::CS_TCK_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_SQ;
      end
      voe_pkg::CS_TCK_S4: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_S2;
      end
      voe_pkg::CS_TCK_S5: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_S4S;
      end
      voe_pkg::CS_TCK_AMP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = voe_pkg::MUL_AMP;
      end
      voe_pkg::CS_TCK_OUT: cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded over an untaken result");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_i.in_mode == voe_pkg::MODE_TICK)) |=> (state_q == voe_pkg::CS_TCK_SQ))
    else $error("tick request did not start the sample sequence");

endmodule

// File: rtl/core/voice_oscillator_envelope_unit.sv
// One synthesizer voice: sin^5 oscillator scaled by a linear attack/release
// envelope, one signed Q1.23 sample per tick request.
// Channels: s_axis carries requests (tuser = mode: tick, attack, release,
// steal, kill; tdata = velocity and phase step). m_axis returns one result
// per tick request only (tdata = sample, tuser = note_ended and active).
// The cfg write channel sets the three envelope step reciprocals; it is
// always ready. The user must write it only while the voice is quiet; the
// block itself has no check for this.
// Sequencing: a tick reads the ROM in the accept cycle, then makes four
// passes through the one shared 32x32 multiplier, and the output register
// is loaded in the state after the last pass; the input is ready for the
// next request in the cycle after that load. An attack makes three
// multiplier passes for the rise, fall and fast-fall steps. Release, steal,
// kill and unused modes complete in the accept cycle, so the input is ready
// again on the next one. One request is worked on at a time.
// Reset: configuration returns to its default reciprocals, the voice is
// idle with zero phase and amplitude; the sine and peak tables are constant.
// Stall: a finished result waits in the output register while the next
// request is accepted; a tick that finishes while that register is still
// full holds in its last step until the receiver takes the old result.
module voice_oscillator_envelope_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // velocity[6:0], phase_step[30:7]
  input  logic [voe_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[2:0]
  // master side result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [voe_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // sample[23:0]
  output logic [1:0]                        m_axis_tuser,  // note_ended[0], active[1]
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [voe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [voe_pkg::CFG_W-1:0]         cfg_data_i
);

  voe_pkg::dp_cmd_t                 cmd;
  voe_pkg::dp_status_t              status;
  logic signed [voe_pkg::SAMPLE_W-1:0] sample;
  logic                             note_ended;
  logic                             active;

  // Configuration never stalls
  assign cfg_ready_o = 1'b1;

  // Sequencer: accept a request, step the shared multiplier, load the result
  voe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Envelope state, phase accumulator, sine ROM, multiplier, output register
  voe_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_mode_i        (s_axis_tuser),
    .in_velocity_i    (s_axis_tdata[6:0]),
    .in_phase_step_i  (s_axis_tdata[30:7]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_sample_o     (sample),
    .out_note_ended_o (note_ended),
    .out_active_o     (active)
  );

  assign m_axis_tdata = sample;
  assign m_axis_tuser = {active, note_ended};

endmodule
